[hdl/rgbhsv_pkg.sv]
// ============================================================================
// rgbhsv_pkg
// Shared types and constants for the RGB to HSV byte converter pipeline.
// ============================================================================
package rgbhsv_pkg;

    localparam int CHAN_W      = 8;                 // one colour channel
    localparam int DIFF_W      = CHAN_W + 1;        // signed channel difference
    localparam int QUOT_W      = 8;                 // hue and saturation quotients
    localparam int REM_W       = 17;                // widest dividend (85 * 1275)
    localparam int DEN_W       = CHAN_W + 1;        // widest divisor (2 * delta)
    localparam int BITS_PER_DIV_STAGE = 2;
    localparam int DIV_STAGES  = QUOT_W / BITS_PER_DIV_STAGE;
    localparam int PREP_STAGES = 2;
    localparam int NSTAGE      = PREP_STAGES + DIV_STAGES + 1;

    localparam logic [7:0] HUE_STEP_EXACT  = 8'd85;  // 42.5 worked on halves
    localparam logic [7:0] HUE_STEP_COARSE = 8'd43;
    localparam logic [7:0] OFFSET_RED      = 8'd0;
    localparam logic [7:0] OFFSET_GREEN    = 8'd85;
    localparam logic [7:0] OFFSET_BLUE     = 8'd171;
    localparam logic [7:0] SAT_SCALE       = 8'd255;

    // Sector chosen by the largest channel, ties to red then green
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // After min/max search
    typedef struct packed {
        logic [CHAN_W-1:0]        max_val;
        logic [CHAN_W-1:0]        delta;
        logic signed [DIFF_W-1:0] diff;
        sector_t                  sector;
        logic                     exact;
    } pix_t;

    // Travels through the divider: two lanes, hue and saturation
    typedef struct packed {
        logic [REM_W-1:0]  rem_h;
        logic [DEN_W-1:0]  den_h;
        logic [QUOT_W-1:0] q_h;
        logic [REM_W-1:0]  rem_s;
        logic [DEN_W-1:0]  den_s;
        logic [QUOT_W-1:0] q_s;
        logic [7:0]        offset;
        logic              neg;
        logic              grey;
        logic [CHAN_W-1:0] max_val;
    } div_item_t;

endpackage

[hdl/rgbhsv_prep.sv]
// ============================================================================
// rgbhsv_prep
// Two pipeline stages: min/max and sector search, then dividend and divisor
// forming for the hue and saturation lanes.
// ============================================================================
module rgbhsv_prep
    import rgbhsv_pkg::*;
(
    input  logic                   aclk,
    input  logic [CHAN_W-1:0]      red,
    input  logic [CHAN_W-1:0]      green,
    input  logic [CHAN_W-1:0]      blue,
    input  logic                   exact_mode,
    input  logic [PREP_STAGES-1:0] load,
    output div_item_t              item_out
);

    pix_t      pix_reg, pix_next;
    div_item_t item_reg, item_next;

    // Stage one: largest and smallest channel, sector, signed difference
    always_comb begin
        logic [CHAN_W-1:0] mx, mn;
        mx = (red > green) ? ((red > blue) ? red : blue)
                           : ((green > blue) ? green : blue);
        mn = (red < green) ? ((red < blue) ? red : blue)
                           : ((green < blue) ? green : blue);
        pix_next.max_val = mx;
        pix_next.delta   = mx - mn;
        pix_next.exact   = exact_mode;
        if (mx == red) begin
            pix_next.sector = SECT_RED;
            pix_next.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (mx == green) begin
            pix_next.sector = SECT_GREEN;
            pix_next.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            pix_next.sector = SECT_BLUE;
            pix_next.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            pix_reg <= pix_next;
        end
    end

    // Stage two: scaled dividends and divisors
    always_comb begin
        logic [DIFF_W-1:0]   abs_wide;
        logic [CHAN_W-1:0]   abs_d;
        logic signed [10:0]  k_green, k_blue;
        logic [10:0]         k_sel;
        logic [7:0]          factor;
        abs_wide = pix_reg.diff[DIFF_W-1] ? DIFF_W'(-pix_reg.diff) : pix_reg.diff;
        abs_d    = abs_wide[CHAN_W-1:0];
        k_green  = $signed({2'b00, pix_reg.delta, 1'b0}) + 11'(pix_reg.diff);
        k_blue   = $signed({1'b0, pix_reg.delta, 2'b00}) + 11'(pix_reg.diff);

        item_next         = '0;
        item_next.max_val = pix_reg.max_val;
        item_next.grey    = (pix_reg.delta == '0);
        item_next.rem_s   = REM_W'(SAT_SCALE) * REM_W'(pix_reg.delta);
        item_next.den_s   = DEN_W'(pix_reg.max_val);

        if (pix_reg.exact) begin
            // Whole sum over twice delta; only the red sector can go negative
            factor            = HUE_STEP_EXACT;
            item_next.den_h   = {pix_reg.delta, 1'b0};
            item_next.offset  = OFFSET_RED;
            case (pix_reg.sector)
                SECT_GREEN: begin
                    k_sel         = k_green;
                    item_next.neg = 1'b0;
                end
                SECT_BLUE: begin
                    k_sel         = k_blue;
                    item_next.neg = 1'b0;
                end
                default: begin
                    k_sel         = 11'(abs_d);
                    item_next.neg = pix_reg.diff[DIFF_W-1];
                end
            endcase
        end else begin
            // Coarse: integer offset plus truncated signed quotient
            factor          = HUE_STEP_COARSE;
            k_sel           = 11'(abs_d);
            item_next.den_h = DEN_W'(pix_reg.delta);
            item_next.neg   = pix_reg.diff[DIFF_W-1];
            case (pix_reg.sector)
                SECT_GREEN: item_next.offset = OFFSET_GREEN;
                SECT_BLUE:  item_next.offset = OFFSET_BLUE;
                default:    item_next.offset = OFFSET_RED;
            endcase
        end
        item_next.rem_h = REM_W'(k_sel) * REM_W'(factor);
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

[hdl/rgbhsv_divider.sv]
// ============================================================================
// rgbhsv_divider
// Pipelined restoring divider, two quotient bits per stage, run on the hue
// and saturation lanes side by side. Quotients are known to fit in 8 bits.
// ============================================================================
module rgbhsv_divider
    import rgbhsv_pkg::*;
(
    input  logic                  aclk,
    input  div_item_t             item_in,
    input  logic [DIV_STAGES-1:0] load,
    output div_item_t             item_out
);

    div_item_t pipe_reg  [DIV_STAGES];
    div_item_t pipe_next [DIV_STAGES];

    // One restoring step on both lanes at quotient bit pos
    function automatic div_item_t div_step(input div_item_t x, input logic [2:0] pos);
        logic [REM_W-1:0] sh_h, sh_s;
        div_item_t        y;
        y    = x;
        sh_h = REM_W'(x.den_h) << pos;
        sh_s = REM_W'(x.den_s) << pos;
        if (y.rem_h >= sh_h) begin
            y.rem_h    = y.rem_h - sh_h;
            y.q_h[pos] = 1'b1;
        end
        if (y.rem_s >= sh_s) begin
            y.rem_s    = y.rem_s - sh_s;
            y.q_s[pos] = 1'b1;
        end
        return y;
    endfunction

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
        localparam int HI = QUOT_W - 1 - BITS_PER_DIV_STAGE * j;

        // Resolve the two next quotient bits, high one first
        always_comb begin
            div_item_t src;
            src          = (j == 0) ? item_in : pipe_reg[(j == 0) ? 0 : j - 1];
            pipe_next[j] = div_step(div_step(src, 3'(HI)), 3'(HI - 1));
        end

        always_ff @(posedge aclk) begin
            if (load[j]) begin
                pipe_reg[j] <= pipe_next[j];
            end
        end
    end

    assign item_out = pipe_reg[DIV_STAGES-1];

endmodule

[hdl/rgbhsv_finish.sv]
// ============================================================================
// rgbhsv_finish
// Output stage: apply sign and sector offset to the hue, zero grey pixels,
// and hold the result until the downstream side takes it.
// ============================================================================
module rgbhsv_finish
    import rgbhsv_pkg::*;
(
    input  logic        aclk,
    input  div_item_t   item_in,
    input  logic        load,
    output logic [23:0] result
);

    logic [23:0] out_reg, out_next;

    // Wrap hue modulo 256, grey gives zero hue and saturation
    always_comb begin
        logic [7:0] q_signed;
        q_signed = item_in.neg ? 8'(-item_in.q_h) : item_in.q_h;
        if (item_in.grey) begin
            out_next = {item_in.max_val, 8'd0, 8'd0};
        end else begin
            out_next = {item_in.max_val, item_in.q_s, 8'(item_in.offset + q_signed)};
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

[hdl/rgb_to_hsv_byte_convert.sv]
// ============================================================================
// rgb_to_hsv_byte_convert
// Streaming RGB to HSV converter on bytes, hue on a 0..255 circle.
// ============================================================================
//  Channel   Direction  Payload (lowest bits first)           Handshake
//  s_        in         red, green, blue                      tvalid/tready
//  m_        out        hue, saturation, brightness           tvalid/tready
//  cfg_      in         exact_mode (bit 0)                    write enable
//
//  One pixel per cycle while the output is not stalled; the pipeline is two
//  forming stages, four divider stages of two quotient bits each, and the output register.
//  Reset clears all stage valid bits and sets exact_mode to 1.
//  Each stage holds while the next is full and stalled; empty stages fill,
//  so input is taken while a result waits at the output.
// ============================================================================
module rgb_to_hsv_byte_convert
    import rgbhsv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input pixel requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    // Result requests
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
    // Mode register
    input  logic        cfg_wen,
    input  logic        cfg_wdata
);

    logic              exact_mode_reg;
    logic [NSTAGE-1:0] valid_reg, valid_next;
    logic [NSTAGE:0]   ready;
    div_item_t         prep_item, div_item;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exact_mode_reg <= 1'b1;
        end else if (cfg_wen) begin
            exact_mode_reg <= cfg_wdata;
        end
    end

    // Stage may load when empty or when its content moves on
    always_comb begin
        ready[NSTAGE] = m_tready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    // Advance valid bits with the data
    always_comb begin
        valid_next = valid_reg;
        for (int k = 0; k < NSTAGE; k++) begin
            if (ready[k]) begin
                valid_next[k] = (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    rgbhsv_prep u_prep (
        .aclk       (aclk),
        .red        (s_tdata[7:0]),
        .green      (s_tdata[15:8]),
        .blue       (s_tdata[23:16]),
        .exact_mode (exact_mode_reg),
        .load       (ready[PREP_STAGES-1:0]),
        .item_out   (prep_item)
    );

    rgbhsv_divider u_divider (
        .aclk     (aclk),
        .item_in  (prep_item),
        .load     (ready[PREP_STAGES+DIV_STAGES-1:PREP_STAGES]),
        .item_out (div_item)
    );

    rgbhsv_finish u_finish (
        .aclk    (aclk),
        .item_in (div_item),
        .load    (ready[NSTAGE-1]),
        .result  (m_tdata)
    );

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NSTAGE-1];

endmodule

[hdl/rgbhsv_checker.sv]
// ============================================================================
// rgbhsv_checker
// Port-level checks on the converter, bound to the top level.
// ============================================================================
module rgbhsv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Drop all results on reset
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Zero saturation only for grey, and then hue is zero too
    a_grey_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[15:8] == 8'd0) |-> (m_tdata[7:0] == 8'd0))
        else $error("hue set on grey pixel");

    // Black carries no saturation
    a_black_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[23:16] == 8'd0) |-> (m_tdata[15:8] == 8'd0))
        else $error("saturation set on black pixel");

endmodule

bind rgb_to_hsv_byte_convert rgbhsv_checker u_checker (.*);
